@@ rtl/core/tlmt_pkg.sv @@
// Shared widths, payload structs and stream layout for the two-line midpoint block.
// Used by every module in rtl/core; it has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package tlmt_pkg;

  localparam int unsigned COORD_BITS      = 24;
  localparam int unsigned PARAM_FRAC_BITS = 24;
  localparam int unsigned NUM_COORDS      = 12;

  // Exact intermediate widths, derived from COORD_BITS, PARAM_FRAC_BITS and LIMB_W.
  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned MUL1_W  = 2 * DIFF_W;
  localparam int unsigned DOT_W   = MUL1_W + 2;
  localparam int unsigned HALF_W  = DOT_W / 2;
  localparam int unsigned PART1_W = 2 * HALF_W + 2;
  localparam int unsigned PROD_W  = 2 * DOT_W;
  localparam int unsigned CROSS_W = PROD_W + 1;
  localparam int unsigned NUM_W   = CROSS_W + PARAM_FRAC_BITS + 1;
  localparam int unsigned DEN_W   = CROSS_W + 1;
  localparam int unsigned QUO_W   = NUM_W - 1;
  localparam int unsigned REM_W   = DEN_W + 1;
  localparam int unsigned THETA_W = QUO_W + 1;
  localparam int unsigned LIMB_W  = 32;
  localparam int unsigned NLIMB   = (THETA_W + LIMB_W - 1) / LIMB_W;
  localparam int unsigned TOP_W   = THETA_W - (NLIMB - 1) * LIMB_W;
  localparam int unsigned PART2_W = DIFF_W + LIMB_W + 1;
  localparam int unsigned MID_W   = DIFF_W + THETA_W + 2;

  // Stream layout.
  localparam int unsigned IN_TDATA_W  = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned USER_DEGENERATE = 0;
  localparam int unsigned USER_SATURATED  = 1;

  typedef logic [NUM_COORDS-1:0][COORD_BITS-1:0] coords_t;
  typedef logic [2:0][DIFF_W-1:0] vec3_t;

  // Per-request data that rides alongside the arithmetic until the midpoint stage.
  typedef struct packed {
    vec3_t u;
    vec3_t v;
    vec3_t base;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic             deg;
    logic             neg_t;
    logic             neg_s;
    logic [NUM_W-1:0] num_t;
    logic [NUM_W-1:0] num_s;
    logic [DEN_W-1:0] den2;
  } div_req_t;

  typedef struct packed {
    side_t            side;
    logic             deg;
    logic             neg_t;
    logic             neg_s;
    logic [QUO_W-1:0] quo_t;
    logic [QUO_W-1:0] quo_s;
  } div_res_t;

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] point;
    logic                       deg;
    logic                       sat;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/tlmt_front.sv @@
// Front pipeline: directions, dot products, cross terms and divider operands.
// Depends on tlmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlmt_front import tlmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  coords_t  coords_i,
  output logic     valid_o,
  output div_req_t req_o
);

  localparam int unsigned NSTAGE = 8;
  // Operand pairs for A*A, B*C, A*E, D*C, B*E and A*D (A..E indexed 0..4).
  localparam int unsigned XSEL [6] = '{0, 1, 0, 3, 1, 0};
  localparam int unsigned YSEL [6] = '{0, 2, 4, 2, 4, 3};

  logic  vld_q  [NSTAGE];
  side_t side_q [NSTAGE];
  side_t side_d;

  logic signed [DIFF_W-1:0]  w_d [3], w_q [3];
  logic signed [MUL1_W-1:0]  mul_d [5][3], mul_q [5][3];
  logic signed [DOT_W-1:0]   dot_d [5], dot_q [5];
  logic signed [PART1_W-1:0] hh_d [6], hl_d [6], lh_d [6], ll_d [6];
  logic signed [PART1_W-1:0] hh_q [6], hl_q [6], lh_q [6], ll_q [6];
  logic signed [PROD_W-1:0]  prod_d [6], prod_q [6];
  logic signed [CROSS_W-1:0] den_d, tn_d, sn_d, den_q, tn_q, sn_q;
  logic [CROSS_W-1:0]        mden_d, mtn_d, msn_d, mden_q, mtn_q, msn_q;
  logic                      deg_d, negt_d, negs_d, deg_q, negt_q, negs_q;
  div_req_t                  req_d, req_q;

  // Stage 1: directions u, v, offset w and the sum of the two target points.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      side_d.u[k]    = DIFF_W'($signed(coords_i[k]))     - DIFF_W'($signed(coords_i[3 + k]));
      side_d.v[k]    = DIFF_W'($signed(coords_i[6 + k]))     - DIFF_W'($signed(coords_i[9 + k]));
      side_d.base[k] = DIFF_W'($signed(coords_i[3 + k])) + DIFF_W'($signed(coords_i[9 + k]));
      w_d[k]         = DIFF_W'($signed(coords_i[9 + k])) - DIFF_W'($signed(coords_i[3 + k]));
    end
  end

  // Stage 2: the fifteen component products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_d[0][k] = $signed(side_q[0].u[k]) * $signed(side_q[0].v[k]);
      mul_d[1][k] = $signed(side_q[0].u[k]) * $signed(side_q[0].u[k]);
      mul_d[2][k] = $signed(side_q[0].v[k]) * $signed(side_q[0].v[k]);
      mul_d[3][k] = $signed(side_q[0].u[k]) * w_q[k];
      mul_d[4][k] = $signed(side_q[0].v[k]) * w_q[k];
    end
  end

  // Stage 3: dot products A..E.
  always_comb begin
    for (int n = 0; n < 5; n++) begin
      dot_d[n] = DOT_W'(mul_q[n][0]) + DOT_W'(mul_q[n][1]) + DOT_W'(mul_q[n][2]);
    end
  end

  // Stage 4: half-word partial products of the six wide products.
  always_comb begin
    for (int p = 0; p < 6; p++) begin
      hh_d[p] = $signed(dot_q[XSEL[p]][DOT_W-1:HALF_W]) * $signed(dot_q[YSEL[p]][DOT_W-1:HALF_W]);
      hl_d[p] = $signed(dot_q[XSEL[p]][DOT_W-1:HALF_W])
              * $signed({1'b0, dot_q[YSEL[p]][HALF_W-1:0]});
      lh_d[p] = $signed({1'b0, dot_q[XSEL[p]][HALF_W-1:0]})
              * $signed(dot_q[YSEL[p]][DOT_W-1:HALF_W]);
      ll_d[p] = $signed({1'b0, dot_q[XSEL[p]][HALF_W-1:0]})
              * $signed({1'b0, dot_q[YSEL[p]][HALF_W-1:0]});
    end
  end

  // Stage 5: recombine the partials.
  always_comb begin
    for (int p = 0; p < 6; p++) begin
      prod_d[p] = (PROD_W'(hh_q[p]) <<< (2 * HALF_W))
                + ((PROD_W'(hl_q[p]) + PROD_W'(lh_q[p])) <<< HALF_W)
                + PROD_W'(ll_q[p]);
    end
  end

  // Stage 6: shared denominator and the two numerators.
  always_comb begin
    den_d = CROSS_W'(prod_q[0]) - CROSS_W'(prod_q[1]);
    tn_d  = CROSS_W'(prod_q[2]) - CROSS_W'(prod_q[3]);
    sn_d  = CROSS_W'(prod_q[4]) - CROSS_W'(prod_q[5]);
  end

  // Stage 7: sign and magnitude.
  always_comb begin
    mden_d = den_q[CROSS_W-1] ? CROSS_W'(-den_q) : CROSS_W'(den_q);
    mtn_d  = tn_q[CROSS_W-1]  ? CROSS_W'(-tn_q)  : CROSS_W'(tn_q);
    msn_d  = sn_q[CROSS_W-1]  ? CROSS_W'(-sn_q)  : CROSS_W'(sn_q);
    deg_d  = (den_q == '0);
    negt_d = tn_q[CROSS_W-1] ^ den_q[CROSS_W-1];
    negs_d = sn_q[CROSS_W-1] ^ den_q[CROSS_W-1];
  end

  // Stage 8: scaled numerators with the half-divisor added for rounding.
  always_comb begin
    req_d.side  = side_q[6];
    req_d.deg   = deg_q;
    req_d.neg_t = negt_q;
    req_d.neg_s = negs_q;
    req_d.num_t = (NUM_W'(mtn_q) << (PARAM_FRAC_BITS + 1)) + NUM_W'(mden_q);
    req_d.num_s = (NUM_W'(msn_q) << (PARAM_FRAC_BITS + 1)) + NUM_W'(mden_q);
    req_d.den2  = DEN_W'(mden_q) << 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTAGE; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NSTAGE; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_d;
      for (int i = 1; i < NSTAGE; i++) side_q[i] <= side_q[i-1];
      w_q    <= w_d;
      mul_q  <= mul_d;
      dot_q  <= dot_d;
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      lh_q   <= lh_d;
      ll_q   <= ll_d;
      prod_q <= prod_d;
      den_q  <= den_d;
      tn_q   <= tn_d;
      sn_q   <= sn_d;
      mden_q <= mden_d;
      mtn_q  <= mtn_d;
      msn_q  <= msn_d;
      deg_q  <= deg_d;
      negt_q <= negt_d;
      negs_q <= negs_d;
      req_q  <= req_d;
    end
  end

  assign valid_o = vld_q[NSTAGE-1];
  assign req_o   = req_q;

endmodule

`default_nettype wire

@@ rtl/core/tlmt_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, two numerators over one divisor.
// Depends on tlmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlmt_div import tlmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  div_req_t req_i,
  output logic     valid_o,
  output div_res_t res_o
);

  typedef struct packed {
    div_req_t         req;
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] rem_s;
    logic [QUO_W-1:0] quo_t;
    logic [QUO_W-1:0] quo_s;
  } div_stage_t;

  div_stage_t stage_q [QUO_W+1];
  logic       vld_q   [QUO_W+1];
  div_stage_t init_d;

  // The top numerator bit never yields a quotient bit: a non-degenerate divisor is at least two.
  always_comb begin
    init_d.req   = req_i;
    init_d.rem_t = REM_W'(req_i.num_t[NUM_W-1]);
    init_d.rem_s = REM_W'(req_i.num_s[NUM_W-1]);
    init_d.quo_t = '0;
    init_d.quo_s = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) stage_q[0] <= init_d;
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_bit
    localparam int unsigned B = QUO_W - 1 - i;
    div_stage_t     stage_d;
    logic [REM_W:0] sh_t, df_t, sh_s, df_s;

    always_comb begin
      stage_d = stage_q[i];
      sh_t = {1'b0, stage_q[i].rem_t[REM_W-2:0], stage_q[i].req.num_t[B]};
      sh_s = {1'b0, stage_q[i].rem_s[REM_W-2:0], stage_q[i].req.num_s[B]};
      df_t = sh_t - {2'b00, stage_q[i].req.den2};
      df_s = sh_s - {2'b00, stage_q[i].req.den2};
      if (!df_t[REM_W]) begin
        stage_d.rem_t    = df_t[REM_W-1:0];
        stage_d.quo_t[B] = 1'b1;
      end else begin
        stage_d.rem_t = sh_t[REM_W-1:0];
      end
      if (!df_s[REM_W]) begin
        stage_d.rem_s    = df_s[REM_W-1:0];
        stage_d.quo_s[B] = 1'b1;
      end else begin
        stage_d.rem_s = sh_s[REM_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) stage_q[i+1] <= stage_d;
    end
  end

  assign valid_o     = vld_q[QUO_W];
  assign res_o.side  = stage_q[QUO_W].req.side;
  assign res_o.deg   = stage_q[QUO_W].req.deg;
  assign res_o.neg_t = stage_q[QUO_W].req.neg_t;
  assign res_o.neg_s = stage_q[QUO_W].req.neg_s;
  assign res_o.quo_t = stage_q[QUO_W].quo_t;
  assign res_o.quo_s = stage_q[QUO_W].quo_s;

endmodule

`default_nettype wire

@@ rtl/core/tlmt_mid.sv @@
// Back pipeline: signed parameters, limb products, midpoint sum, rounding and clamping.
// Depends on tlmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlmt_mid import tlmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  div_res_t res_i,
  output logic     valid_o,
  output result_t  result_o
);

  localparam int unsigned NSTAGE = 7;

  logic  vld_q  [NSTAGE];
  side_t side_q [NSTAGE];
  logic  deg_q  [NSTAGE];

  logic signed [THETA_W-1:0] th_d, sg_d, th_q, sg_q;
  logic signed [PART2_W-1:0] pu_d [3][NLIMB], pv_d [3][NLIMB];
  logic signed [PART2_W-1:0] pu_q [3][NLIMB], pv_q [3][NLIMB];
  logic signed [MID_W-1:0]   ut_d [3], vt_d [3], bs_d [3];
  logic signed [MID_W-1:0]   ut_q [3], vt_q [3], bs_q [3];
  logic signed [MID_W-1:0]   num_d [3], num_q [3];
  logic [MID_W-1:0]          mag_d [3], mag_q [3], rnd_d [3], rnd_q [3];
  logic                      neg_d [3], neg5_q [3], neg6_q [3];
  logic [MID_W-1:0]          lim;
  result_t                   res_d, res_q;

  // Stage 1: apply the quotient signs.
  always_comb begin
    th_d = res_i.neg_t ? -THETA_W'(res_i.quo_t) : THETA_W'(res_i.quo_t);
    sg_d = res_i.neg_s ? -THETA_W'(res_i.quo_s) : THETA_W'(res_i.quo_s);
  end

  // Stage 2: direction times each limb (32 bits, the top one 2 bits); only the top limb is signed.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < NLIMB - 1; j++) begin
        pu_d[k][j] = $signed(side_q[0].u[k]) * $signed({1'b0, th_q[j*LIMB_W +: LIMB_W]});
        pv_d[k][j] = $signed(side_q[0].v[k]) * $signed({1'b0, sg_q[j*LIMB_W +: LIMB_W]});
      end
      pu_d[k][NLIMB-1] = $signed(side_q[0].u[k])
                       * $signed(th_q[THETA_W-1:(NLIMB-1)*LIMB_W]);
      pv_d[k][NLIMB-1] = $signed(side_q[0].v[k])
                       * $signed(sg_q[THETA_W-1:(NLIMB-1)*LIMB_W]);
    end
  end

  // Stage 3: assemble u*theta, v*sigma and the scaled base term.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ut_d[k] = '0;
      vt_d[k] = '0;
      for (int j = 0; j < NLIMB; j++) begin
        ut_d[k] = ut_d[k] + (MID_W'(pu_q[k][j]) <<< (j * LIMB_W));
        vt_d[k] = vt_d[k] + (MID_W'(pv_q[k][j]) <<< (j * LIMB_W));
      end
      bs_d[k] = MID_W'($signed(side_q[1].base[k])) <<< PARAM_FRAC_BITS;
    end
  end

  // Stage 4: twice the midpoint in fixed point.
  always_comb begin
    for (int k = 0; k < 3; k++) num_d[k] = bs_q[k] + ut_q[k] + vt_q[k];
  end

  // Stage 5: sign and magnitude.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_d[k] = num_q[k][MID_W-1];
      mag_d[k] = neg_d[k] ? MID_W'(-num_q[k]) : MID_W'(num_q[k]);
    end
  end

  // Stage 6: round half away from zero on the magnitude.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd_d[k] = (mag_q[k] + (MID_W'(1) << PARAM_FRAC_BITS)) >> (PARAM_FRAC_BITS + 1);
    end
  end

  // Stage 7: clamp to the coordinate range; degenerate input gives the origin.
  always_comb begin
    lim       = MID_W'(1) << (COORD_BITS - 1);
    res_d.deg = deg_q[5];
    res_d.sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (neg6_q[k]) begin
        if (rnd_q[k] > lim) begin
          res_d.point[k] = {1'b1, {(COORD_BITS-1){1'b0}}};
          res_d.sat      = 1'b1;
        end else begin
          res_d.point[k] = COORD_BITS'(-rnd_q[k][COORD_BITS-1:0]);
        end
      end else begin
        if (rnd_q[k] >= lim) begin
          res_d.point[k] = {1'b0, {(COORD_BITS-1){1'b1}}};
          res_d.sat      = 1'b1;
        end else begin
          res_d.point[k] = rnd_q[k][COORD_BITS-1:0];
        end
      end
    end
    if (deg_q[5]) begin
      res_d.point = '0;
      res_d.sat   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTAGE; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NSTAGE; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= res_i.side;
      deg_q[0]  <= res_i.deg;
      for (int i = 1; i < NSTAGE; i++) begin
        side_q[i] <= side_q[i-1];
        deg_q[i]  <= deg_q[i-1];
      end
      th_q   <= th_d;
      sg_q   <= sg_d;
      pu_q   <= pu_d;
      pv_q   <= pv_d;
      ut_q   <= ut_d;
      vt_q   <= vt_d;
      bs_q   <= bs_d;
      num_q  <= num_d;
      mag_q  <= mag_d;
      neg5_q <= neg_d;
      rnd_q  <= rnd_d;
      neg6_q <= neg5_q;
      res_q  <= res_d;
    end
  end

  assign valid_o  = vld_q[NSTAGE-1];
  assign result_o = res_q;

endmodule

`default_nettype wire

@@ rtl/core/two_line_midpoint_triangulation_top.sv @@
// Pipeline with 24-bit coordinates: 8 front stages, 130 divider stages (an operand
// register and 129 quotient-bit stages) and 7 back stages; the divider chain is the longest.
// Throughput: one request per cycle while m_axis_tready does not stall the output register.
// Reset: rst_ni is asynchronous and active low; it clears every valid bit, so the
// pipeline comes out of reset empty and ready. Payload registers are not reset.
// Depends on tlmt_pkg, tlmt_front, tlmt_div and tlmt_mid.
`timescale 1ns / 1ps
`default_nettype none

module two_line_midpoint_triangulation_top import tlmt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: line_a_origin_x, _y, _z, line_a_target_x, _y, _z,
  // line_b_origin_x, _y, _z, line_b_target_x, _y, _z.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0 up: point_x, point_y, point_z.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0 up: degenerate, saturated.
  output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  // The whole pipeline shares one advance signal. The last stage of the back
  // pipeline is the output register, so the pipeline moves whenever that
  // register is empty or its result is being taken; bubbles inside the pipe
  // travel along with the data and cost nothing.
  logic     en;
  logic     front_valid, div_valid, mid_valid;
  div_req_t div_req;
  div_res_t div_res;
  result_t  result;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  tlmt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .coords_i (s_axis_tdata[NUM_COORDS*COORD_BITS-1:0]),
    .valid_o  (front_valid),
    .req_o    (div_req)
  );

  // Both line parameters share the denominator, so one divider pipe carries
  // both numerators side by side.
  tlmt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .req_i   (div_req),
    .valid_o (div_valid),
    .res_o   (div_res)
  );

  tlmt_mid u_mid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (div_valid),
    .res_i    (div_res),
    .valid_o  (mid_valid),
    .result_o (result)
  );

  assign m_axis_tvalid = mid_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(result.point);
  assign m_axis_tuser  = {result.sat, result.deg};

endmodule

`default_nettype wire

@@ rtl/core/tlmt_checker.sv @@
// Port-level checks for the two-line midpoint block, attached to the top level by bind.
// Depends on tlmt_pkg and two_line_midpoint_triangulation_top.
`timescale 1ns / 1ps
`default_nettype none

module tlmt_checker import tlmt_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  logic [2:0] at_bound;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      at_bound[k] = (m_axis_tdata[k*COORD_BITS +: COORD_BITS] == {1'b1, {(COORD_BITS-1){1'b0}}})
                 || (m_axis_tdata[k*COORD_BITS +: COORD_BITS] == {1'b0, {(COORD_BITS-1){1'b1}}});
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USER_DEGENERATE] |->
      m_axis_tdata == '0 && !m_axis_tuser[USER_SATURATED])
    else $error("degenerate result is not a clean zero point");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USER_SATURATED] |-> at_bound != 3'b000)
    else $error("saturated result has no coordinate at a bound");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind two_line_midpoint_triangulation_top tlmt_checker u_tlmt_checker (.*);

`default_nettype wire
